### hdl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int LEN_W           = 24;
	localparam int MAX_RESET       = 8192;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_RESERVED = 3'd1;
	localparam logic [2:0] ERR_FIN      = 3'd2;
	localparam logic [2:0] ERR_MASKED   = 3'd3;
	localparam logic [2:0] ERR_NONCANON = 3'd4;
	localparam logic [2:0] ERR_TOO_LONG = 3'd5;

	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_EXT     = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_HALT    = 3'd4;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       payload_byte;
		logic [3:0]       opcode;
		logic [LEN_W-1:0] payload_length;
		logic             header_done;
		logic             last_of_frame;
		logic [2:0]       error_code;
	} result_t;

endpackage

### hdl/wsfd_parser.sv
// Frame header parser state and per-byte result logic.
module wsfd_parser #(
	parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       cmd,
	input  logic [7:0]                 data_byte,
	input  logic [wsfd_pkg::LEN_W-1:0] max_payload,
	output wsfd_pkg::result_t          result
);

	logic [2:0]                 phase_q, phase_n;
	logic [3:0]                 opcode_q, opcode_n;
	logic                       long_q, long_n;
	logic [3:0]                 lbl_q, lbl_n;
	logic [wsfd_pkg::LEN_W-1:0] acc_q, acc_n;
	logic                       ovf_q, ovf_n;
	logic [LENGTH_BITS-1:0]     pleft_q, pleft_n;

	logic [wsfd_pkg::LEN_W-1:0] len;
	logic [wsfd_pkg::LEN_W-1:0] floor_len;
	logic                       fin_hdr;
	logic [2:0]                 err;
	logic [6:0]                 l7;

	always_comb begin
		phase_n  = phase_q;
		opcode_n = opcode_q;
		long_n   = long_q;
		lbl_n    = lbl_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		pleft_n  = pleft_q;
		len      = '0;
		fin_hdr  = 1'b0;
		err      = wsfd_pkg::ERR_NONE;
		l7       = data_byte[6:0];
		floor_len = long_q ? wsfd_pkg::LEN_W'(16'hFFFF) : wsfd_pkg::LEN_W'(7'd125);
		result   = '0;
		result.kind = wsfd_pkg::KIND_HEADER;

		if (cmd) begin
			phase_n  = wsfd_pkg::PH_FIRST;
			opcode_n = '0;
			long_n   = 1'b0;
			lbl_n    = '0;
			acc_n    = '0;
			ovf_n    = 1'b0;
			pleft_n  = '0;
			result.kind = wsfd_pkg::KIND_IGNORED;
		end else begin
			case (phase_q)
				wsfd_pkg::PH_FIRST: begin
					if (data_byte[6:4] != 3'd0) begin
						err = wsfd_pkg::ERR_RESERVED;
					end else if (!data_byte[7]) begin
						err = wsfd_pkg::ERR_FIN;
					end else begin
						opcode_n = data_byte[3:0];
						phase_n  = wsfd_pkg::PH_SECOND;
					end
				end
				wsfd_pkg::PH_SECOND: begin
					if (data_byte[7]) begin
						err = wsfd_pkg::ERR_MASKED;
					end else if (l7 == 7'd126 || l7 == 7'd127) begin
						long_n  = (l7 == 7'd127);
						lbl_n   = (l7 == 7'd127) ? 4'd8 : 4'd2;
						acc_n   = '0;
						ovf_n   = 1'b0;
						phase_n = wsfd_pkg::PH_EXT;
					end else if (wsfd_pkg::LEN_W'(l7) > max_payload) begin
						err = wsfd_pkg::ERR_TOO_LONG;
					end else begin
						len     = wsfd_pkg::LEN_W'(l7);
						fin_hdr = 1'b1;
					end
				end
				wsfd_pkg::PH_EXT: begin
					// Only the low 24 bits are kept; anything shifted out above them
					// makes the length larger than any cap, so a sticky flag suffices.
					acc_n = {acc_q[wsfd_pkg::LEN_W-9:0], data_byte};
					ovf_n = ovf_q | (acc_q[wsfd_pkg::LEN_W-1:wsfd_pkg::LEN_W-8] != 8'd0);
					lbl_n = lbl_q - 4'd1;
					if (lbl_n == 4'd0) begin
						if (!ovf_n && acc_n <= floor_len) begin
							err = wsfd_pkg::ERR_NONCANON;
						end else if (ovf_n || acc_n > max_payload) begin
							err = wsfd_pkg::ERR_TOO_LONG;
						end else begin
							len     = acc_n;
							fin_hdr = 1'b1;
						end
					end
				end
				wsfd_pkg::PH_PAYLOAD: begin
					result.kind         = wsfd_pkg::KIND_PAYLOAD;
					result.payload_byte = data_byte;
					pleft_n             = pleft_q - LENGTH_BITS'(1);
					if (pleft_n == '0) begin
						result.last_of_frame = 1'b1;
						phase_n              = wsfd_pkg::PH_FIRST;
					end
				end
				default: begin
					result.kind = wsfd_pkg::KIND_IGNORED;
				end
			endcase
		end

		if (fin_hdr) begin
			result.payload_length = len;
			result.header_done    = 1'b1;
			if (len == '0) begin
				result.last_of_frame = 1'b1;
				phase_n              = wsfd_pkg::PH_FIRST;
			end else begin
				pleft_n = LENGTH_BITS'(len);
				phase_n = wsfd_pkg::PH_PAYLOAD;
			end
		end

		if (err != wsfd_pkg::ERR_NONE) begin
			result.kind           = wsfd_pkg::KIND_ERROR;
			result.error_code     = err;
			result.payload_length = '0;
			result.header_done    = 1'b0;
			result.last_of_frame  = 1'b0;
			phase_n               = wsfd_pkg::PH_HALT;
		end

		result.opcode = opcode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfd_pkg::PH_FIRST;
			opcode_q <= '0;
			long_q   <= 1'b0;
			lbl_q    <= '0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			pleft_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			long_q   <= long_n;
			lbl_q    <= lbl_n;
			acc_q    <= acc_n;
			ovf_q    <= ovf_n;
			pleft_q  <= pleft_n;
		end
	end

endmodule

### hdl/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: input register, parser, result register.
//
//   channel   signals                                          direction
//   -------   ----------------------------------------------   ---------
//   input     in_valid, in_stall, cmd, data_byte               in (stall out)
//   output    out_valid, out_stall, kind, payload_byte,        out (stall in)
//             opcode, payload_length, header_done,
//             last_of_frame, error_code
//   config    cfg_we, cfg_wdata (max_payload)                  in
//
// One byte is taken every cycle while in_stall is low; each transfer produces exactly one
// result, passing the input register, then the result register, set by the single
// parser stage between them. Reset clears the parser to the first header
// byte and sets max_payload to 8192. A stall on the output holds the result
// register, which in turn stalls the input register; the input side is
// stalled only while both registers are full and the output cannot move.
module websocket_frame_deframer_unit #(
	parameter int LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [wsfd_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 kind,
	output logic [7:0]                 payload_byte,
	output logic [3:0]                 opcode,
	output logic [wsfd_pkg::LEN_W-1:0] payload_length,
	output logic                       header_done,
	output logic                       last_of_frame,
	output logic [2:0]                 error_code
);

	// The cap is masked to the length width the parser counts in.
	localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_BITS) - 64'd1;
	localparam logic [wsfd_pkg::LEN_W-1:0] CAP_MASK = LEN_MASK[wsfd_pkg::LEN_W-1:0];
	localparam logic [wsfd_pkg::LEN_W-1:0] CAP_RESET =
		wsfd_pkg::LEN_W'(wsfd_pkg::MAX_RESET) & CAP_MASK;

	logic [wsfd_pkg::LEN_W-1:0] max_payload_q;

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic              out_valid_q;
	wsfd_pkg::result_t result_s2;
	wsfd_pkg::result_t result_n;

	// The first stage moves on whenever the result register is empty or draining.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= CAP_RESET;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata & CAP_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			byte_s1 <= data_byte;
		end
	end

	wsfd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cmd         (cmd_s1),
		.data_byte   (byte_s1),
		.max_payload (max_payload_q),
		.result      (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = result_s2.kind;
	assign payload_byte   = result_s2.payload_byte;
	assign opcode         = result_s2.opcode;
	assign payload_length = result_s2.payload_length;
	assign header_done    = result_s2.header_done;
	assign last_of_frame  = result_s2.last_of_frame;
	assign error_code     = result_s2.error_code;

endmodule
